@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the blocks that check their own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
		else $error("assertion failed");

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/pcle_pkg.sv @@
// ----------------------------------------------------------------------------
// pcle_pkg
// Types, codes and helpers shared by the positional circular list engine.
// ----------------------------------------------------------------------------
package pcle_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 6;
	localparam int VAL_W    = 32;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic signed [VAL_W-1:0] val_t;

	// Command codes.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic en;
		idx_t addr;
	} node_rd_req_t;

	typedef struct packed {
		val_t value;
		idx_t nxt;
		idx_t prv;
	} node_rd_t;

	typedef struct packed {
		logic val_en;
		idx_t val_addr;
		val_t val_data;
		logic nxt_en;
		idx_t nxt_addr;
		idx_t nxt_data;
		logic prv_en;
		idx_t prv_addr;
		idx_t prv_data;
	} node_wr_t;

	typedef struct packed {
		logic pop;
		logic push;
		idx_t push_idx;
	} fs_req_t;

	typedef struct packed {
		idx_t pop_idx;
		logic empty;
		cnt_t top;
	} fs_rsp_t;

	typedef struct packed {
		logic busy;
		cnt_t elem_count;
	} ctrl_stat_t;

	// Maps an out-of-range link to slot zero.
	function automatic idx_t slot(input idx_t x);
		slot = (int'(x) < CAPACITY) ? x : idx_t'(0);
	endfunction

endpackage

@@ hdl/pcle_node_store.sv @@
// ----------------------------------------------------------------------------
// pcle_node_store
// Node memories: value, next link and previous link, one read port shared
// by all three with registered read data, and one write port per memory.
// ----------------------------------------------------------------------------
module pcle_node_store (
	input  logic                   clk,
	input  pcle_pkg::node_rd_req_t rd_req,
	input  pcle_pkg::node_wr_t     wr,
	output pcle_pkg::node_rd_t     rd
);

	pcle_pkg::val_t val_mem [pcle_pkg::CAPACITY];
	pcle_pkg::idx_t nxt_mem [pcle_pkg::CAPACITY];
	pcle_pkg::idx_t prv_mem [pcle_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.val_en) begin
			val_mem[wr.val_addr] <= wr.val_data;
		end
		if (wr.nxt_en) begin
			nxt_mem[wr.nxt_addr] <= wr.nxt_data;
		end
		if (wr.prv_en) begin
			prv_mem[wr.prv_addr] <= wr.prv_data;
		end
	end

	// Read data holds when no read is issued, so a stalled dump keeps its item.
	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd.value <= val_mem[rd_req.addr];
			rd.nxt   <= nxt_mem[rd_req.addr];
			rd.prv   <= prv_mem[rd_req.addr];
		end
	end

endmodule

@@ hdl/pcle_free_stack.sv @@
// ----------------------------------------------------------------------------
// pcle_free_stack
// Stack of free node slots in a synchronous memory. Pop data is registered and
// appears in the cycle after the pop. A low-water mark stands in for the reset contents.
// ----------------------------------------------------------------------------
module pcle_free_stack (
	input  logic              clk,
	input  logic              arst_n,
	input  pcle_pkg::fs_req_t req,
	output pcle_pkg::fs_rsp_t rsp
);

	pcle_pkg::idx_t mem [pcle_pkg::CAPACITY];
	pcle_pkg::cnt_t top_q;
	pcle_pkg::cnt_t low_q;
	logic           fresh_s1;
	pcle_pkg::idx_t idx_s1;
	pcle_pkg::idx_t rd_s1;
	pcle_pkg::idx_t pop_addr;
	logic           push_ok;

	assign pop_addr = pcle_pkg::idx_t'(top_q - pcle_pkg::cnt_t'(1));
	assign push_ok  = req.push && (int'(top_q) < pcle_pkg::CAPACITY);

	// Pops and pushes never share a cycle, and a pop never reads the entry
	// written in the same cycle, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[top_q[pcle_pkg::IDX_W-1:0]] <= req.push_idx;
		end
		if (req.pop) begin
			rd_s1 <= mem[pop_addr];
		end
	end

	// Entries below the lowest top ever reached have never been written and
	// still hold their reset contents, which descend from the top slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= pcle_pkg::cnt_t'(pcle_pkg::CAPACITY);
			low_q    <= pcle_pkg::cnt_t'(pcle_pkg::CAPACITY);
			fresh_s1 <= 1'b0;
			idx_s1   <= '0;
		end else begin
			if (req.pop) begin
				top_q    <= top_q - pcle_pkg::cnt_t'(1);
				fresh_s1 <= ({1'b0, pop_addr} < low_q);
				idx_s1   <= pop_addr;
				if ({1'b0, pop_addr} < low_q) begin
					low_q <= {1'b0, pop_addr};
				end
			end else if (push_ok) begin
				top_q <= top_q + pcle_pkg::cnt_t'(1);
			end
		end
	end

	assign rsp.pop_idx = fresh_s1 ? (pcle_pkg::idx_t'(pcle_pkg::CAPACITY - 1) - idx_s1) : rd_s1;
	assign rsp.empty   = (top_q == '0);
	assign rsp.top     = top_q;

endmodule

@@ hdl/pcle_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcle_ctrl
// Sequencer: decodes commands, walks the ring through the node store,
// rewrites links, keeps head, tail and count, and holds the output register.
// ----------------------------------------------------------------------------
module pcle_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             command,
	input  logic [5:0]             position,
	input  pcle_pkg::val_t         value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output pcle_pkg::val_t         element,
	output pcle_pkg::cnt_t         count,
	output logic                   last,
	output pcle_pkg::node_rd_req_t node_rq,
	output pcle_pkg::node_wr_t     node_wr,
	input  pcle_pkg::node_rd_t     node_rd,
	output pcle_pkg::fs_req_t      fs_rq,
	input  pcle_pkg::fs_rsp_t      fs_rsp,
	output pcle_pkg::ctrl_stat_t   stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_POPW,
		S_WALK,
		S_WSTEP,
		S_RDT,
		S_TGT,
		S_INS_B,
		S_RESP,
		S_DRD,
		S_DOUT
	} state_t;

	state_t         state_q;
	logic           is_ins_q;
	logic [5:0]     pos_q;
	pcle_pkg::val_t val_q;
	pcle_pkg::idx_t head_q;
	pcle_pkg::idx_t tail_q;
	pcle_pkg::cnt_t count_q;
	pcle_pkg::idx_t cur_q;
	pcle_pkg::cnt_t steps_q;
	pcle_pkg::idx_t new_q;
	pcle_pkg::idx_t pred_q;
	pcle_pkg::idx_t succ_q;
	logic [1:0]     status_q;
	pcle_pkg::cnt_t rem_q;

	logic           out_free;
	logic           out_load;
	logic           ins_bad;
	logic           ins_full;
	logic           del_bad;
	pcle_pkg::idx_t walk_nxt;
	pcle_pkg::idx_t del_pred;

	assign out_free = !out_valid || !out_stall;
	assign out_load = out_free && ((state_q == S_RESP) || (state_q == S_DOUT));
	assign ins_bad  = (position == '0) || ({1'b0, position} > ({1'b0, count_q} + 7'd1));
	assign ins_full = fs_rsp.empty || (int'(count_q) >= pcle_pkg::CAPACITY);
	assign del_bad  = (position == '0) || (position > count_q);
	assign walk_nxt = pcle_pkg::slot(node_rd.nxt);
	assign del_pred = pcle_pkg::slot(node_rd.prv);
	assign in_stall = (state_q != S_IDLE);
	assign stat.busy       = (state_q != S_IDLE);
	assign stat.elem_count = count_q;

	// Memory requests. The sequence never reads an entry in the cycle it is
	// written, which keeps the read-modify-write free of hazards.
	always_comb begin
		node_rq = '0;
		node_wr = '0;
		fs_rq   = '0;
		unique case (state_q)
			S_IDLE: begin
				fs_rq.pop = in_valid && (command == pcle_pkg::CMD_INSERT) && !ins_bad && !ins_full;
			end
			S_POPW: begin
				if (count_q == '0) begin
					node_wr.val_en   = 1'b1;
					node_wr.val_addr = fs_rsp.pop_idx;
					node_wr.val_data = val_q;
					node_wr.nxt_en   = 1'b1;
					node_wr.nxt_addr = fs_rsp.pop_idx;
					node_wr.nxt_data = fs_rsp.pop_idx;
					node_wr.prv_en   = 1'b1;
					node_wr.prv_addr = fs_rsp.pop_idx;
					node_wr.prv_data = fs_rsp.pop_idx;
				end
			end
			S_WALK: begin
				node_rq.en   = (steps_q != '0);
				node_rq.addr = cur_q;
			end
			S_WSTEP: begin
				node_rq.en   = (steps_q != '0);
				node_rq.addr = walk_nxt;
			end
			S_RDT, S_DRD: begin
				node_rq.en   = 1'b1;
				node_rq.addr = cur_q;
			end
			S_TGT: begin
				if (is_ins_q) begin
					node_wr.val_en   = 1'b1;
					node_wr.val_addr = new_q;
					node_wr.val_data = val_q;
					node_wr.nxt_en   = 1'b1;
					node_wr.nxt_addr = new_q;
					node_wr.nxt_data = walk_nxt;
					node_wr.prv_en   = 1'b1;
					node_wr.prv_addr = new_q;
					node_wr.prv_data = cur_q;
				end else begin
					fs_rq.push     = 1'b1;
					fs_rq.push_idx = cur_q;
					if (count_q != pcle_pkg::cnt_t'(1)) begin
						node_wr.nxt_en   = 1'b1;
						node_wr.nxt_addr = del_pred;
						node_wr.nxt_data = walk_nxt;
						node_wr.prv_en   = 1'b1;
						node_wr.prv_addr = walk_nxt;
						node_wr.prv_data = del_pred;
					end
				end
			end
			S_INS_B: begin
				node_wr.nxt_en   = 1'b1;
				node_wr.nxt_addr = pred_q;
				node_wr.nxt_data = new_q;
				node_wr.prv_en   = 1'b1;
				node_wr.prv_addr = succ_q;
				node_wr.prv_data = new_q;
			end
			S_DOUT: begin
				node_rq.en   = out_free && (rem_q != pcle_pkg::cnt_t'(1));
				node_rq.addr = walk_nxt;
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			is_ins_q  <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pos_q    <= position;
						val_q    <= value;
						cur_q    <= head_q;
						status_q <= pcle_pkg::ST_BADPOS;
						state_q  <= S_RESP;
						case (command)
							pcle_pkg::CMD_INSERT: begin
								is_ins_q <= 1'b1;
								if (!ins_bad && ins_full) begin
									status_q <= pcle_pkg::ST_FULL;
								end else if (!ins_bad) begin
									state_q <= S_POPW;
								end
							end
							pcle_pkg::CMD_DELETE: begin
								is_ins_q <= 1'b0;
								if (!del_bad) begin
									steps_q <= position - pcle_pkg::cnt_t'(1);
									state_q <= S_WALK;
								end
							end
							pcle_pkg::CMD_DUMP: begin
								if (count_q == '0) begin
									status_q <= pcle_pkg::ST_EMPTY;
								end else begin
									rem_q   <= count_q;
									state_q <= S_DRD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_POPW: begin
					new_q <= fs_rsp.pop_idx;
					if (count_q == '0) begin
						head_q   <= fs_rsp.pop_idx;
						tail_q   <= fs_rsp.pop_idx;
						count_q  <= pcle_pkg::cnt_t'(1);
						status_q <= pcle_pkg::ST_OK;
						state_q  <= S_RESP;
					end else if (pos_q == 6'd1) begin
						cur_q   <= tail_q;
						state_q <= S_RDT;
					end else begin
						cur_q   <= head_q;
						steps_q <= pos_q - pcle_pkg::cnt_t'(2);
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (steps_q == '0) begin
						state_q <= S_RDT;
					end else begin
						steps_q <= steps_q - pcle_pkg::cnt_t'(1);
						state_q <= S_WSTEP;
					end
				end
				S_WSTEP: begin
					// Each cycle follows one next link; the address comes
					// straight from the previous read.
					cur_q <= walk_nxt;
					if (steps_q == '0) begin
						state_q <= S_RDT;
					end else begin
						steps_q <= steps_q - pcle_pkg::cnt_t'(1);
					end
				end
				S_RDT: begin
					state_q <= S_TGT;
				end
				S_TGT: begin
					if (is_ins_q) begin
						pred_q  <= cur_q;
						succ_q  <= walk_nxt;
						state_q <= S_INS_B;
					end else begin
						if (count_q == pcle_pkg::cnt_t'(1)) begin
							head_q <= '0;
							tail_q <= '0;
						end else begin
							if (pos_q == 6'd1) begin
								head_q <= walk_nxt;
							end
							if (pos_q == count_q) begin
								tail_q <= del_pred;
							end
						end
						count_q  <= count_q - pcle_pkg::cnt_t'(1);
						status_q <= pcle_pkg::ST_OK;
						state_q  <= S_RESP;
					end
				end
				S_INS_B: begin
					if (pos_q == 6'd1) begin
						head_q <= new_q;
					end
					if (pos_q == (count_q + pcle_pkg::cnt_t'(1))) begin
						tail_q <= new_q;
					end
					count_q  <= count_q + pcle_pkg::cnt_t'(1);
					status_q <= pcle_pkg::ST_OK;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						status    <= status_q;
						element   <= '0;
						count     <= count_q;
						last      <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_DRD: begin
					state_q <= S_DOUT;
				end
				S_DOUT: begin
					if (out_free) begin
						status    <= pcle_pkg::ST_OK;
						element   <= node_rd.value;
						count     <= count_q;
						last      <= (rem_q == pcle_pkg::cnt_t'(1));
						if (rem_q == pcle_pkg::cnt_t'(1)) begin
							state_q <= S_IDLE;
						end else begin
							cur_q <= walk_nxt;
							rem_q <= rem_q - pcle_pkg::cnt_t'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/positional_circular_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// positional_circular_list_engine_unit
// Ordered list of signed 32-bit values kept as a doubly linked ring.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries command, position and value.
// Insert places value at one-based position 1..count+1, delete removes the
// item at position 1..count, dump emits every value from head to tail.
// Output channel (out_valid / out_stall) carries status, element, count and
// last. Insert, delete and every rejected command give one item with last
// set; a dump gives one item per stored value, last on the final one.
// One item is processed at a time; in_stall is high until its final result
// has been loaded into the output register.
// A rejected command goes straight to its response. A delete, or an insert at
// position p >= 2, walks the links through the single read port of the node
// store, one link per cycle; an insert at position 1 reads the tail instead,
// and an insert into an empty list reads nothing. A dump reads one node per
// output item.
// While out_valid and out_stall are high the result register holds and a dump waits.
// Reset empties the list and frees every node; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_circular_list_engine_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [5:0]           position,
	input  logic signed [31:0]   value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic signed [31:0]   element,
	output logic [5:0]           count,
	output logic                 last
);

	pcle_pkg::node_rd_req_t node_rq;
	pcle_pkg::node_wr_t     node_wr;
	pcle_pkg::node_rd_t     node_rd;
	pcle_pkg::fs_req_t      fs_rq;
	pcle_pkg::fs_rsp_t      fs_rsp;
	pcle_pkg::ctrl_stat_t   stat;

	pcle_node_store u_nodes (
		.clk    (clk),
		.rd_req (node_rq),
		.wr     (node_wr),
		.rd     (node_rd)
	);

	pcle_free_stack u_free (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fs_rq),
		.rsp    (fs_rsp)
	);

	pcle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.element   (element),
		.count     (count),
		.last      (last),
		.node_rq   (node_rq),
		.node_wr   (node_wr),
		.node_rd   (node_rd),
		.fs_rq     (fs_rq),
		.fs_rsp    (fs_rsp),
		.stat      (stat)
	);

	// Between items every node is either linked or on the free stack.
	`ASSERT_IMPL(a_nodes_conserved, clk, arst_n, !stat.busy, (int'(stat.elem_count) + int'(fs_rsp.top)) == pcle_pkg::CAPACITY)
	// Error and empty results are single items with a zero element.
	`ASSERT_IMPL(a_status_single, clk, arst_n, out_valid && (status != pcle_pkg::ST_OK), last && (element == '0))
	// A slot is only taken from the free stack when one is there.
	`ASSERT_ALWAYS(a_pop_nonempty, clk, arst_n, !fs_rq.pop || !fs_rsp.empty)

endmodule
